// ----- rtl/dtts_pkg.sv -----
// Shared constants and types for the duration text to seconds core.
package dtts_pkg;

    localparam int TOTAL_W = 62;
    localparam int PEND_W  = 63;
    localparam int MAG_W   = 64;
    localparam int SCALE_W = 18;
    localparam int UNITS   = 4;
    localparam int UIDX_W  = 2;
    localparam int PHASE_W = 3;

    // Unit sum ceiling, 2^62-1
    localparam logic [TOTAL_W-1:0] SUM_CAP   = {TOTAL_W{1'b1}};
    localparam logic [MAG_W-1:0]   POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [MAG_W-1:0]   NEG_LIMIT = 64'h8000_0000_0000_0000;

    localparam logic [SCALE_W-1:0] SEC_MIN  = 18'd60;
    localparam logic [SCALE_W-1:0] SEC_HOUR = 18'd3600;
    localparam logic [SCALE_W-1:0] SEC_DAY  = 18'(8 * 3600);
    localparam logic [SCALE_W-1:0] SEC_WEEK = 18'(5 * 8 * 3600);

    // Unit indexes; the scale table below follows this order
    localparam logic [UIDX_W-1:0] U_MIN  = 2'd0;
    localparam logic [UIDX_W-1:0] U_HOUR = 2'd1;
    localparam logic [UIDX_W-1:0] U_DAY  = 2'd2;
    localparam logic [UIDX_W-1:0] U_WEEK = 2'd3;

    localparam logic [SCALE_W-1:0] UNIT_SCALE [UNITS] = '{SEC_MIN, SEC_HOUR, SEC_DAY, SEC_WEEK};

    // Whole-integer reading phases
    localparam logic [PHASE_W-1:0] PH_LEAD   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SIGN   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_DIGITS = 3'd2;
    localparam logic [PHASE_W-1:0] PH_TRAIL  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_FAIL   = 3'd4;

    // Characters
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Text state captured on the end-of-text request
    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic [PEND_W-1:0]  pend;
        logic               pend_on;
        logic               stop;
        logic               cap;
        logic               whole;
        logic               neg;
        logic [MAG_W-1:0]   mag;
    } snap_t;

endpackage

// ----- rtl/duration_text_to_seconds_core.sv -----
// Duration text to seconds: streaming byte parser with integer and unit-sum readings.
//
// Text bytes enter on the slave stream, one request per cycle, and each text ends on the
// request with tlast high; that request yields one result on the master stream, no other
// request yields any. Sustained rate is one byte per clock with no gaps between texts while
// results drain. After its end-of-text request is taken, a result passes an input register
// that feeds the per-byte update (one 10x multiply-add and compare per reading, one saturating
// add for the unit sum), an end-of-text snapshot register that feeds the closing add of a
// digit run still open, and an output register that holds the result. Scaled copies of the
// open digit run (by 60, 3600, 28800 and 144000) are kept up to date with every digit, so
// closing a term costs one add. The input side keeps taking bytes while a result waits; only
// an end-of-text request waits for the snapshot stage to clear. Result seconds is the signed
// integer when the whole text reads as one (tuser[0] set), otherwise the unit sum capped at
// 2^62-1 (tuser[1] set if the cap was taken). There are no configuration registers.
module duration_text_to_seconds_core
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic [0:0]  s_axis_tuser,   // [0] has_byte
    input  logic        s_axis_tlast,   // end_of_text

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [63:0] seconds (signed)
    output logic [1:0]  m_axis_tuser    // [0] whole_form, [1] saturated
);

    localparam int TW = dtts_pkg::TOTAL_W;
    localparam int PW = dtts_pkg::PEND_W;
    localparam int MW = dtts_pkg::MAG_W;
    localparam int NU = dtts_pkg::UNITS;

    // Input register
    logic        in_valid_reg;
    logic [7:0]  byte_reg;
    logic        has_reg;
    logic        last_reg;

    // Unit sum state
    logic [TW-1:0] total_reg,   total_next;
    logic [PW-1:0] pend_reg,    pend_next;
    logic          pend_on_reg, pend_on_next;
    logic          stop_reg,    stop_next;
    logic          cap_reg,     cap_next;
    logic [TW-1:0] prod_reg  [NU];
    logic [TW-1:0] prod_next [NU];
    logic [NU-1:0] over_reg,    over_next;

    // Whole-integer state
    logic [dtts_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic                         neg_reg,   neg_next;
    logic [MW-1:0]                mag_reg,   mag_next;

    // Snapshot and output stages
    logic            fin_valid_reg;
    dtts_pkg::snap_t fin_reg;
    dtts_pkg::snap_t snap;
    logic            out_valid_reg;
    logic [63:0]     out_data_reg, out_data_next;
    logic [1:0]      out_user_reg, out_user_next;

    // Handshake
    logic out_free, fin_free, fin_move, proc;

    // Byte decode
    logic                         digit, blank, wspace, is_unit;
    logic [3:0]                   dval;
    logic [dtts_pkg::UIDX_W-1:0]  unit_idx;

    // Datapath
    logic [TW-1:0] term_val;
    logic          term_over;
    logic [TW:0]   term_sum;
    logic          term_cap;
    logic [PW+3:0] pend_x10;
    logic          pend_ovf;
    logic [21:0]   d_scaled [NU];
    logic [TW+3:0] prod_x10 [NU];
    logic [MW+3:0] mag_x10;
    logic [MW-1:0] mag_lim;
    logic [TW:0]   fin_add;
    logic [TW-1:0] fin_total;
    logic          fin_cap;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign fin_free      = !fin_valid_reg || out_free;
    assign fin_move      = fin_valid_reg && out_free;
    // An end-of-text request waits for the snapshot stage; other bytes always proceed
    assign proc          = in_valid_reg && (!last_reg || fin_free);
    assign s_axis_tready = !in_valid_reg || proc;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // Decode the held byte
    always_comb
    begin
        digit    = (byte_reg >= dtts_pkg::CH_ZERO) && (byte_reg <= dtts_pkg::CH_NINE);
        dval     = byte_reg[3:0];
        blank    = byte_reg inside {dtts_pkg::CH_SPACE, dtts_pkg::CH_TAB};
        wspace   = byte_reg inside {dtts_pkg::CH_SPACE, [dtts_pkg::CH_TAB:dtts_pkg::CH_CR]};
        is_unit  = 1'b1;
        unit_idx = dtts_pkg::U_MIN;
        case (byte_reg)
            8'h77, 8'h57: unit_idx = dtts_pkg::U_WEEK;   // w W
            8'h64, 8'h44: unit_idx = dtts_pkg::U_DAY;    // d D
            8'h68, 8'h48: unit_idx = dtts_pkg::U_HOUR;   // h H
            8'h6D, 8'h4D: unit_idx = dtts_pkg::U_MIN;    // m M
            default:      is_unit  = 1'b0;
        endcase
    end

    // Term value: open run scaled by the closing character, or a lone character counted once at its scale
    always_comb
    begin
        if (pend_on_reg) begin
            if (is_unit) begin
                term_val  = prod_reg[unit_idx];
                term_over = over_reg[unit_idx];
            end
            else
            begin
                term_val  = pend_reg[TW-1:0];
                term_over = pend_reg[PW-1];
            end
        end
        else
        begin
            term_over = 1'b0;
            term_val  = is_unit ? TW'(dtts_pkg::UNIT_SCALE[unit_idx]) : TW'(1);
        end
        term_sum = {1'b0, total_reg} + {1'b0, term_val};
        term_cap = term_over || (term_sum > {1'b0, dtts_pkg::SUM_CAP});
    end

    // Digit pushes: run times ten plus digit, and the same for each scaled copy
    always_comb
    begin
        pend_x10 = ({4'b0, pend_reg} << 3) + ({4'b0, pend_reg} << 1) + (PW+4)'(dval);
        pend_ovf = pend_x10 > (PW+4)'(dtts_pkg::POS_LIMIT);
        for (int k = 0; k < NU; k++) begin
            d_scaled[k] = 22'(dval) * 22'(dtts_pkg::UNIT_SCALE[k]);
            prod_x10[k] = ({4'b0, prod_reg[k]} << 3) + ({4'b0, prod_reg[k]} << 1)
                        + (TW+4)'(d_scaled[k]);
        end
        mag_x10 = ({4'b0, mag_reg} << 3) + ({4'b0, mag_reg} << 1) + (MW+4)'(dval);
        mag_lim = neg_reg ? dtts_pkg::NEG_LIMIT : dtts_pkg::POS_LIMIT;
    end

    // Unit sum update
    always_comb
    begin
        total_next   = total_reg;
        pend_next    = pend_reg;
        pend_on_next = pend_on_reg;
        stop_next    = stop_reg;
        cap_next     = cap_reg;
        prod_next    = prod_reg;
        over_next    = over_reg;
        if (has_reg && !stop_reg) begin
            if (pend_on_reg && digit) begin
                if (pend_ovf) begin
                    stop_next = 1'b1;
                end
                else
                begin
                    pend_next = pend_x10[PW-1:0];
                    for (int k = 0; k < NU; k++) begin
                        if (!over_reg[k]) begin
                            prod_next[k] = prod_x10[k][TW-1:0];
                            over_next[k] = prod_x10[k] > (TW+4)'(dtts_pkg::SUM_CAP);
                        end
                    end
                end
            end
            else if (digit) begin
                pend_next    = PW'(dval);
                pend_on_next = 1'b1;
                over_next    = '0;
                for (int k = 0; k < NU; k++) begin
                    prod_next[k] = TW'(d_scaled[k]);
                end
            end
            else if (pend_on_reg || !blank) begin
                if (term_cap) begin
                    total_next = dtts_pkg::SUM_CAP;
                    cap_next   = 1'b1;
                end
                else
                begin
                    total_next = term_sum[TW-1:0];
                end
                pend_next    = '0;
                pend_on_next = 1'b0;
                over_next    = '0;
                for (int k = 0; k < NU; k++) begin
                    prod_next[k] = '0;
                end
            end
        end
    end

    // Whole-integer reading
    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        if (has_reg) begin
            case (phase_reg)
                dtts_pkg::PH_LEAD:
                begin
                    if (wspace) begin
                        phase_next = phase_reg;
                    end
                    else if (byte_reg inside {dtts_pkg::CH_PLUS, dtts_pkg::CH_MINUS}) begin
                        neg_next   = (byte_reg == dtts_pkg::CH_MINUS);
                        phase_next = dtts_pkg::PH_SIGN;
                    end
                    else if (digit) begin
                        mag_next   = MW'(dval);
                        phase_next = dtts_pkg::PH_DIGITS;
                    end
                    else
                    begin
                        phase_next = dtts_pkg::PH_FAIL;
                    end
                end
                dtts_pkg::PH_SIGN:
                begin
                    if (digit) begin
                        mag_next   = MW'(dval);
                        phase_next = dtts_pkg::PH_DIGITS;
                    end
                    else
                    begin
                        phase_next = dtts_pkg::PH_FAIL;
                    end
                end
                dtts_pkg::PH_DIGITS:
                begin
                    if (digit) begin
                        if (mag_x10 > (MW+4)'(mag_lim)) begin
                            phase_next = dtts_pkg::PH_FAIL;
                        end
                        else
                        begin
                            mag_next = mag_x10[MW-1:0];
                        end
                    end
                    else
                    begin
                        phase_next = blank ? dtts_pkg::PH_TRAIL : dtts_pkg::PH_FAIL;
                    end
                end
                dtts_pkg::PH_TRAIL:
                begin
                    if (!blank) begin
                        phase_next = dtts_pkg::PH_FAIL;
                    end
                end
                default: phase_next = dtts_pkg::PH_FAIL;
            endcase
        end
    end

    // Capture the text at its end
    always_comb
    begin
        snap.total   = total_next;
        snap.pend    = pend_next;
        snap.pend_on = pend_on_next;
        snap.stop    = stop_next;
        snap.cap     = cap_next;
        snap.whole   = (phase_next == dtts_pkg::PH_DIGITS) || (phase_next == dtts_pkg::PH_TRAIL);
        snap.neg     = neg_next;
        snap.mag     = mag_next;
    end

    // Close an open run at scale one and pick the reading
    always_comb
    begin
        fin_add   = {1'b0, fin_reg.total} + {1'b0, fin_reg.pend[TW-1:0]};
        fin_total = fin_reg.total;
        fin_cap   = fin_reg.cap;
        if (!fin_reg.stop && fin_reg.pend_on) begin
            if (fin_reg.pend[PW-1] || (fin_add > {1'b0, dtts_pkg::SUM_CAP})) begin
                fin_total = dtts_pkg::SUM_CAP;
                fin_cap   = 1'b1;
            end
            else
            begin
                fin_total = fin_add[TW-1:0];
            end
        end
        if (fin_reg.whole) begin
            out_data_next = fin_reg.neg ? (MW'(0) - fin_reg.mag) : fin_reg.mag;
            out_user_next = 2'b01;
        end
        else
        begin
            out_data_next = {2'b00, fin_total};
            out_user_next = {fin_cap, 1'b0};
        end
    end

    // Control and text state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
            pend_reg      <= '0;
            pend_on_reg   <= 1'b0;
            stop_reg      <= 1'b0;
            cap_reg       <= 1'b0;
            over_reg      <= '0;
            phase_reg     <= dtts_pkg::PH_LEAD;
            neg_reg       <= 1'b0;
            mag_reg       <= '0;
            for (int k = 0; k < NU; k++) begin
                prod_reg[k] <= '0;
            end
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready) begin
                in_valid_reg <= 1'b1;
            end
            else if (proc) begin
                in_valid_reg <= 1'b0;
            end

            if (proc && last_reg) begin
                fin_valid_reg <= 1'b1;
            end
            else if (fin_move) begin
                fin_valid_reg <= 1'b0;
            end

            if (fin_move) begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end

            if (proc) begin
                if (last_reg) begin
                    // Clear for the next text
                    total_reg   <= '0;
                    pend_reg    <= '0;
                    pend_on_reg <= 1'b0;
                    stop_reg    <= 1'b0;
                    cap_reg     <= 1'b0;
                    over_reg    <= '0;
                    phase_reg   <= dtts_pkg::PH_LEAD;
                    neg_reg     <= 1'b0;
                    mag_reg     <= '0;
                    for (int k = 0; k < NU; k++) begin
                        prod_reg[k] <= '0;
                    end
                end
                else
                begin
                    total_reg   <= total_next;
                    pend_reg    <= pend_next;
                    pend_on_reg <= pend_on_next;
                    stop_reg    <= stop_next;
                    cap_reg     <= cap_next;
                    over_reg    <= over_next;
                    phase_reg   <= phase_next;
                    neg_reg     <= neg_next;
                    mag_reg     <= mag_next;
                    prod_reg    <= prod_next;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready) begin
            byte_reg <= s_axis_tdata;
            has_reg  <= s_axis_tuser[0];
            last_reg <= s_axis_tlast;
        end
        if (proc && last_reg) begin
            fin_reg <= snap;
        end
        if (fin_move) begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

`ifndef SYNTHESIS
    // An integer result never carries the cap flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> !m_axis_tuser[1])
        else $error("integer result flagged as capped");

    // A unit sum never exceeds 2^62-1
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[63:62] == 2'b00))
        else $error("unit sum above cap");

    // The sum only freezes inside an open digit run
    assert property (@(posedge clk) disable iff (!rst_n)
        stop_reg |-> pend_on_reg)
        else $error("sum frozen without open run");

    // No open run leaves no leftover run value or overflow marks
    assert property (@(posedge clk) disable iff (!rst_n)
        !pend_on_reg |-> ((pend_reg == '0) && (over_reg == '0)))
        else $error("stale digit run");

    // An ended text leaves the state cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        (proc && last_reg) |=> ((phase_reg == dtts_pkg::PH_LEAD) && !pend_on_reg
                                && (total_reg == '0) && !cap_reg))
        else $error("state not cleared after end of text");
`endif

endmodule

// ----- bench/dtts_checker.sv -----
// Stream monitor that predicts each duration result and compares it with the core's output.
module dtts_checker
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic [0:0]  s_axis_tuser,   // [0] has_byte
    input  logic        s_axis_tlast,   // end_of_text

    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,   // [63:0] seconds (signed)
    input  logic [1:0]  m_axis_tuser,   // [0] whole_form, [1] saturated

    output int          fail_count,
    output int          awaiting,
    output int          checked,
    output int          whole_hits,
    output int          capped_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [63:0] seconds;
        logic        whole;
        logic        sat;
    } duration_t;

    localparam logic [63:0] CAP64 = 64'(dtts_pkg::SUM_CAP);

    duration_t due_seconds_q[$];

    // Own copy of the text state
    logic [63:0]                  sum_total;
    logic [63:0]                  run_value;
    logic                         run_open;
    logic                         sum_frozen;
    logic                         sum_hit_cap;
    logic [dtts_pkg::PHASE_W-1:0] int_phase;
    logic                         int_neg;
    logic [63:0]                  int_mag;

    function automatic bit is_digit(logic [7:0] c);
        return c >= dtts_pkg::CH_ZERO && c <= dtts_pkg::CH_NINE;
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == dtts_pkg::CH_SPACE || c == dtts_pkg::CH_TAB;
    endfunction

    function automatic bit is_space(logic [7:0] c);
        return c == dtts_pkg::CH_SPACE || (c >= dtts_pkg::CH_TAB && c <= dtts_pkg::CH_CR);
    endfunction

    function automatic logic [63:0] scale_of(logic [7:0] c);
        case (c)
            "w", "W": return 64'(dtts_pkg::SEC_WEEK);
            "d", "D": return 64'(dtts_pkg::SEC_DAY);
            "h", "H": return 64'(dtts_pkg::SEC_HOUR);
            "m", "M": return 64'(dtts_pkg::SEC_MIN);
            default:  return 64'd1;
        endcase
    endfunction

    // True if acc*10+d stays at or below limit
    function automatic bit digit_fits(logic [63:0] acc, logic [3:0] d, logic [63:0] limit);
        return acc <= (limit - 64'(d)) / 64'd10;
    endfunction

    function automatic void clear_text();
        sum_total   = '0;
        run_value   = '0;
        run_open    = 1'b0;
        sum_frozen  = 1'b0;
        sum_hit_cap = 1'b0;
        int_phase   = dtts_pkg::PH_LEAD;
        int_neg     = 1'b0;
        int_mag     = '0;
    endfunction

    function automatic void add_term(logic [63:0] num, logic [63:0] per);
        logic [63:0] added;
        if (num != 0 && num > CAP64 / per)
        begin
            sum_total   = CAP64;
            sum_hit_cap = 1'b1;
        end
        else
        begin
            added = num * per;
            if (sum_total > CAP64 - added)
            begin
                sum_total   = CAP64;
                sum_hit_cap = 1'b1;
            end
            else
            begin
                sum_total = sum_total + added;
            end
        end
    endfunction

    function automatic void read_integer(logic [7:0] c);
        logic [63:0] limit;
        limit = int_neg ? dtts_pkg::NEG_LIMIT : dtts_pkg::POS_LIMIT;
        case (int_phase)
            dtts_pkg::PH_LEAD, dtts_pkg::PH_SIGN:
            begin
                if (!(int_phase == dtts_pkg::PH_LEAD && is_space(c)))
                begin
                    if (int_phase == dtts_pkg::PH_LEAD &&
                        (c == dtts_pkg::CH_PLUS || c == dtts_pkg::CH_MINUS))
                    begin
                        int_neg   = (c == dtts_pkg::CH_MINUS);
                        int_phase = dtts_pkg::PH_SIGN;
                    end
                    else if (is_digit(c))
                    begin
                        int_mag   = 64'(c[3:0]);
                        int_phase = dtts_pkg::PH_DIGITS;
                    end
                    else
                    begin
                        int_phase = dtts_pkg::PH_FAIL;
                    end
                end
            end
            dtts_pkg::PH_DIGITS:
            begin
                if (is_digit(c))
                begin
                    if (digit_fits(int_mag, c[3:0], limit))
                        int_mag = int_mag * 64'd10 + 64'(c[3:0]);
                    else
                        int_phase = dtts_pkg::PH_FAIL;
                end
                else
                begin
                    int_phase = is_blank(c) ? dtts_pkg::PH_TRAIL : dtts_pkg::PH_FAIL;
                end
            end
            dtts_pkg::PH_TRAIL:
            begin
                if (!is_blank(c))
                    int_phase = dtts_pkg::PH_FAIL;
            end
            default: int_phase = dtts_pkg::PH_FAIL;
        endcase
    endfunction

    function automatic void read_units(logic [7:0] c);
        if (!sum_frozen)
        begin
            if (run_open)
            begin
                if (is_digit(c))
                begin
                    if (digit_fits(run_value, c[3:0], dtts_pkg::POS_LIMIT))
                        run_value = run_value * 64'd10 + 64'(c[3:0]);
                    else
                        sum_frozen = 1'b1;
                end
                else
                begin
                    add_term(run_value, scale_of(c));
                    run_open  = 1'b0;
                    run_value = '0;
                end
            end
            else if (is_digit(c))
            begin
                run_value = 64'(c[3:0]);
                run_open  = 1'b1;
            end
            else if (!is_blank(c))
            begin
                add_term(64'd1, scale_of(c));
            end
        end
    endfunction

    // Close the text and queue its result
    function automatic void close_text();
        duration_t d;
        if (!sum_frozen && run_open)
            add_term(run_value, 64'd1);
        if (int_phase == dtts_pkg::PH_DIGITS || int_phase == dtts_pkg::PH_TRAIL)
        begin
            d.seconds = int_neg ? (64'd0 - int_mag) : int_mag;
            d.whole   = 1'b1;
            d.sat     = 1'b0;
        end
        else
        begin
            d.seconds = sum_total;
            d.whole   = 1'b0;
            d.sat     = sum_hit_cap;
        end
        due_seconds_q.push_back(d);
        clear_text();
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        duration_t want;
        if (!rst_n)
        begin
            clear_text();
            due_seconds_q.delete();
            fail_count  <= 0;
            awaiting    <= 0;
            checked     <= 0;
            whole_hits  <= 0;
            capped_hits <= 0;
        end
        else
        begin
            // Results first: an output never belongs to a request taken at the same edge
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (due_seconds_q.size() == 0)
                begin
                    $error("result with nothing expected: seconds=%0d user=%b",
                           $signed(m_axis_tdata), m_axis_tuser);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = due_seconds_q.pop_front();
                    checked     <= checked + 1;
                    whole_hits  <= whole_hits + int'(want.whole);
                    capped_hits <= capped_hits + int'(want.sat);
                    if (m_axis_tdata !== want.seconds ||
                        m_axis_tuser[0] !== want.whole ||
                        m_axis_tuser[1] !== want.sat)
                        fail_count <= fail_count + 1;
                    if (m_axis_tdata !== want.seconds)
                        $error("seconds: expected %0d, got %0d",
                               $signed(want.seconds), $signed(m_axis_tdata));
                    if (m_axis_tuser[0] !== want.whole)
                        $error("whole_form: expected %b, got %b", want.whole, m_axis_tuser[0]);
                    if (m_axis_tuser[1] !== want.sat)
                        $error("saturated: expected %b, got %b", want.sat, m_axis_tuser[1]);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser[0])
                begin
                    read_integer(s_axis_tdata);
                    read_units(s_axis_tdata);
                end
                if (s_axis_tlast)
                    close_text();
            end
            awaiting <= due_seconds_q.size();
        end
    end

endmodule

// ----- bench/tb_top.sv -----
// Top of the duration text bench: clock, reset, text stimulus, receiver and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASE_ITEMS    = 610;   // random requests per idling phase
    localparam int RX_HOLD_CYCLES = 400;   // long receiver hold-off
    localparam int TAIL_CYCLES    = 8;     // settle time after the last result

    logic        clk = 1'b0;
    logic        rst_n;

    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] text_byte
    logic [0:0]  s_axis_tuser;   // [0] has_byte
    logic        s_axis_tlast;   // end_of_text

    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // [63:0] seconds (signed)
    logic [1:0]  m_axis_tuser;   // [0] whole_form, [1] saturated

    int fail_count;
    int awaiting;
    int checked;
    int whole_hits;
    int capped_hits;

    // Idle odds in percent, set per phase by the stimulus
    int tx_idle_pct;
    int rx_idle_pct;

    // Receiver hold-off handshake between the two processes; each side writes its own count
    int hold_asked;
    int hold_done;

    int items_sent;
    int texts_sent;

    logic [7:0] text_q[$];

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    duration_text_to_seconds_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    dtts_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .awaiting      (awaiting),
        .checked       (checked),
        .whole_hits    (whole_hits),
        .capped_hits   (capped_hits)
    );

    // Hard stop in case the core hangs
    initial
    begin
        #10ms;
        $display("tb_top NOT OK");
        $finish;
    end

    // Receiver: random back-pressure, plus one long hold-off on request. While it holds,
    // the output and snapshot stages fill and the core stalls end-of-text requests.
    initial
    begin
        m_axis_tready = 1'b0;
        hold_done     = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_done != hold_asked)
            begin
                hold_done = hold_done + 1;
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
            end
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Offer one request and hold it until the core takes it; idle gaps drop tvalid first
    task automatic send_item(input logic [7:0] b, input logic has, input logic last);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= has;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        items_sent = items_sent + 1;
    endtask

    // Send the bytes in text_q as one text. end_apart closes it with a byte-less request;
    // noisy sprinkles ignored requests (no byte, no end) between the bytes.
    task automatic send_text(input bit end_apart, input bit noisy);
        int  n;
        bit  split;
        n     = text_q.size();
        split = end_apart || (n == 0);
        for (int i = 0; i < n; i++)
        begin
            if (noisy && $urandom_range(0, 24) == 0)
                send_item(8'($urandom), 1'b0, 1'b0);
            send_item(text_q[i], 1'b1, (i == n - 1) && !split);
        end
        if (split)
            send_item(8'($urandom), 1'b0, 1'b1);
        texts_sent = texts_sent + 1;
    endtask

    task automatic load_str(input string s);
        text_q.delete();
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    task automatic push_digits(input int n);
        repeat (n) text_q.push_back(dtts_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // Any of the six leading whitespace characters
    function automatic logic [7:0] pick_space();
        int k;
        k = $urandom_range(0, 5);
        return (k == 0) ? dtts_pkg::CH_SPACE : dtts_pkg::CH_TAB + 8'(k - 1);
    endfunction

    function automatic logic [7:0] pick_blank();
        return $urandom_range(0, 1) ? dtts_pkg::CH_SPACE : dtts_pkg::CH_TAB;
    endfunction

    // Mostly a unit letter, now and then any byte at all
    function automatic logic [7:0] pick_unit();
        string units;
        units = "wWdDhHmM";
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom);
        return units[$urandom_range(0, 7)];
    endfunction

    // Build one random text in text_q; most are well formed, the rest broken or noise
    task automatic compose_text();
        int          kind;
        logic [63:0] v;
        text_q.delete();
        kind = $urandom_range(0, 99);
        if (kind < 30)
        begin
            // plain integer with optional whitespace and sign
            repeat ($urandom_range(0, 2)) text_q.push_back(pick_space());
            case ($urandom_range(0, 3))
                0: text_q.push_back(dtts_pkg::CH_PLUS);
                1: text_q.push_back(dtts_pkg::CH_MINUS);
                default: ;
            endcase
            push_digits($urandom_range(1, ($urandom_range(0, 4) == 0) ? 19 : 6));
            repeat ($urandom_range(0, 2)) text_q.push_back(pick_blank());
        end
        else if (kind < 40)
        begin
            // integers around the signed 64-bit edges, or the largest unsigned value
            if ($urandom_range(0, 5) == 0)
                v = '1;
            else
                v = dtts_pkg::POS_LIMIT - 64'd2 + 64'($urandom_range(0, 4));
            if ($urandom_range(0, 1))
                text_q.push_back(dtts_pkg::CH_MINUS);
            push_str($sformatf("%0d", v));
            if ($urandom_range(0, 3) == 0)
                text_q.push_back(pick_blank());
        end
        else if (kind < 75)
        begin
            // unit terms, some without a number, some blanks between
            repeat ($urandom_range(1, 4))
            begin
                if ($urandom_range(0, 3) != 0)
                    push_digits($urandom_range(1, 5));
                text_q.push_back(pick_unit());
                if ($urandom_range(0, 2) == 0)
                    text_q.push_back(pick_blank());
            end
            if ($urandom_range(0, 3) == 0)
                push_digits($urandom_range(1, 3));
        end
        else if (kind < 85)
        begin
            // huge runs: hit the sum cap or overflow the digit run
            repeat ($urandom_range(1, 3))
            begin
                push_digits($urandom_range(12, 21));
                text_q.push_back(pick_unit());
            end
        end
        else if (kind < 93)
        begin
            // integer spoiled by a stray character
            push_digits($urandom_range(1, 4));
            text_q.push_back(8'($urandom));
            if ($urandom_range(0, 1))
                push_digits($urandom_range(1, 3));
        end
        else
        begin
            // raw byte noise, possibly empty
            repeat ($urandom_range(0, 6)) text_q.push_back(8'($urandom));
        end
    endtask

    // Hold stimulus until every predicted result has left the core
    task automatic drain();
        @(posedge clk);
        while (awaiting != 0) @(posedge clk);
    endtask

    initial
    begin
        int target;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        hold_asked    = 0;
        items_sent    = 0;
        texts_sent    = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed texts: empty end, ignored request, hour term, signed integer with trailing blanks,
        // unit sum, non-ASCII byte, lone sign after VT, blank text, end apart from digits
        text_q.delete();
        send_text(1'b1, 1'b0);
        send_item(8'hA5, 1'b0, 1'b0);
        load_str("3h");
        send_text(1'b0, 1'b0);
        load_str("-12 \t");
        send_text(1'b0, 1'b0);
        load_str("2w1d");
        send_text(1'b0, 1'b0);
        text_q.delete();
        text_q.push_back(8'hFF);
        send_text(1'b0, 1'b0);
        text_q.delete();
        text_q.push_back(8'h0B);
        text_q.push_back(dtts_pkg::CH_PLUS);
        send_text(1'b0, 1'b0);
        load_str(" \t");
        send_text(1'b0, 1'b0);
        load_str("7");
        send_text(1'b1, 1'b0);
        s_axis_tvalid <= 1'b0;
        drain();

        // Random phases: sender rarely idles, then receiver rarely idles, then no idling
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    tx_idle_pct = 6;
                    rx_idle_pct = 49;
                end
                1:
                begin
                    tx_idle_pct = 49;
                    rx_idle_pct = 6;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            if (phase == 0)
                hold_asked = hold_asked + 1;
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                compose_text();
                send_text($urandom_range(0, 7) == 0, 1'b1);
            end
            s_axis_tvalid <= 1'b0;
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d texts in %0d requests under three idling mixes and a long hold-off.",
                 texts_sent, items_sent);
        $display("Checked %0d results: %0d plain integers, %0d capped unit sums.",
                 checked, whole_hits, capped_hits);
        if (fail_count == 0 && awaiting == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
